// ===== hdl/peer_session_table_with_loss_count_top_defines.svh =====
// Assertion macros used by the peer session table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PEER_SESSION_TABLE_WITH_LOSS_COUNT_TOP_DEFINES_SVH
`define PEER_SESSION_TABLE_WITH_LOSS_COUNT_TOP_DEFINES_SVH

// Implication check, disabled while reset is asserted.
`define PSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psl assertion failed");

// Invariant check, disabled while reset is asserted.
`define PSL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("psl assertion failed");

`endif

// ===== hdl/psl_pkg.sv =====
// Package for the peer session table: types, status codes, register map.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package psl_pkg;

    localparam int SLOTS_DEF = 4;

    localparam logic [31:0] RESET_TIMEOUT_MS = 32'd5000;
    localparam logic [31:0] RESET_SWEEP_MS   = 32'd1000;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_TYPE    = 3'd4;
    localparam logic [2:0] ST_PAYLOAD = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MAGIC     = 3'd0;
    localparam logic [2:0] REG_VERSION   = 3'd1;
    localparam logic [2:0] REG_TYPE      = 3'd2;
    localparam logic [2:0] REG_HDR_BYTES = 3'd3;
    localparam logic [2:0] REG_PKT_BYTES = 3'd4;
    localparam logic [2:0] REG_TIMEOUT   = 3'd5;
    localparam logic [2:0] REG_SWEEP     = 3'd6;

    localparam int ADDR_W = 5;

    // job queue between classifier and table engine
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 64;

    typedef struct packed {
        logic [15:0] expected_magic;
        logic [7:0]  expected_version;
        logic [7:0]  input_type_code;
        logic [15:0] header_bytes;
        logic [15:0] input_packet_bytes;
        logic [31:0] idle_timeout_ms;
        logic [31:0] sweep_interval_ms;
    } psl_cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] seq_number;
        logic [31:0] source_ip;
        logic [31:0] now_ms;
    } psl_job_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_index;
        logic        new_peer;
        logic [15:0] gap_now;
        logic [31:0] gap_total;
        logic [2:0]  peers_active;
    } psl_result_t;

endpackage

// ===== hdl/psl_front.sv =====
// Front end: unpacks an input item and runs the header checks.
// Depends on psl_pkg; feeds psl_queue.
`timescale 1ns / 1ps

module psl_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [psl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  psl_pkg::psl_cfg_t               cfg,
    input  logic                            q_full,
    output logic                            q_push,
    output psl_pkg::psl_job_t               q_job
);
    import psl_pkg::*;

    logic [15:0] pkt_len;
    logic [15:0] magic_value;
    logic [7:0]  version_value;
    logic [7:0]  type_code;
    logic [2:0]  status;

    assign pkt_len       = s_tdata[15:0];
    assign magic_value   = s_tdata[31:16];
    assign version_value = s_tdata[39:32];
    assign type_code     = s_tdata[47:40];

    // first failing check wins
    always_comb begin
        if (pkt_len < cfg.header_bytes) begin
            status = ST_SHORT;
        end else if (magic_value != cfg.expected_magic) begin
            status = ST_MAGIC;
        end else if (version_value != cfg.expected_version) begin
            status = ST_VERSION;
        end else if (type_code != cfg.input_type_code) begin
            status = ST_TYPE;
        end else if (pkt_len < cfg.input_packet_bytes) begin
            status = ST_PAYLOAD;
        end else begin
            status = ST_OK;
        end
    end

    assign s_tready         = !q_full;
    assign q_push           = s_tvalid && !q_full;
    assign q_job.status     = status;
    assign q_job.seq_number = s_tdata[63:48];
    assign q_job.source_ip  = s_tdata[95:64];
    assign q_job.now_ms     = s_tdata[127:96];

endmodule

// ===== hdl/psl_queue.sv =====
// Short job queue between the classifier and the table engine.
// Depends on psl_pkg.
`timescale 1ns / 1ps

module psl_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  psl_pkg::psl_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output psl_pkg::psl_job_t head_job
);
    import psl_pkg::*;

    psl_job_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg;
    logic [QUEUE_AW:0]   rd_ptr_reg;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                      (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head_job = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/psl_back.sv =====
// Back end: timeout sweep, slot lookup/claim, gap counting, result register.
// Depends on psl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "peer_session_table_with_loss_count_top_defines.svh"

module psl_back #(
    parameter int SLOTS = psl_pkg::SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psl_pkg::psl_cfg_t     cfg,
    input  logic                  job_valid,
    input  psl_pkg::psl_job_t     job,
    output logic                  job_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output psl_pkg::psl_result_t  out_data
);
    import psl_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // slot table
    logic [SLOTS-1:0] slot_active_reg;
    logic [31:0]      slot_ip_reg        [SLOTS];
    logic [15:0]      slot_last_seq_reg  [SLOTS];
    logic [31:0]      slot_last_seen_reg [SLOTS];
    logic [31:0]      slot_pkt_count_reg [SLOTS];
    logic [31:0]      slot_gap_total_reg [SLOTS];

    logic [2:0]        state_reg,       state_next;
    logic [SLOT_W-1:0] idx_reg,         idx_next;
    logic [SLOT_W-1:0] sel_reg,         sel_next;
    logic [SLOT_W-1:0] free_idx_reg,    free_idx_next;
    logic              free_found_reg,  free_found_next;
    logic              fresh_reg,       fresh_next;
    psl_job_t          job_reg,         job_next;
    logic [2:0]        res_status_reg,  res_status_next;
    logic [15:0]       gap_reg,         gap_next;
    logic [31:0]       total_reg,       total_next;
    logic [CNT_W-1:0]  active_cnt_reg,  active_cnt_next;
    logic [31:0]       last_sweep_reg,  last_sweep_next;
    logic              out_valid_reg,   out_valid_next;
    psl_result_t       out_data_reg,    out_data_next;

    logic        sweep_due;
    logic        expire;
    logic        hit;
    logic        last_idx;
    logic        clear_slot;
    logic        write_slot;
    logic [15:0] expect_seq;
    logic        has_gap;
    logic [15:0] upd_gap;
    logic [31:0] upd_total;
    logic        res_ok;

    assign sweep_due = (job_reg.now_ms - last_sweep_reg) > cfg.sweep_interval_ms;
    assign expire    = slot_active_reg[idx_reg] &&
                       ((job_reg.now_ms - slot_last_seen_reg[idx_reg]) > cfg.idle_timeout_ms);
    assign hit       = slot_active_reg[idx_reg] &&
                       (slot_ip_reg[idx_reg] == job_reg.source_ip);
    assign last_idx  = (idx_reg == LAST_SLOT);

    // gap arithmetic on the selected slot; a freshly claimed slot has no history
    assign expect_seq = slot_last_seq_reg[sel_reg] + 16'd1;
    assign has_gap    = !fresh_reg && (slot_pkt_count_reg[sel_reg] != 32'd0) &&
                        (job_reg.seq_number != expect_seq);
    assign upd_gap    = has_gap ? (job_reg.seq_number - expect_seq) : 16'd0;
    assign upd_total  = fresh_reg ? 32'd0 : (slot_gap_total_reg[sel_reg] + {16'd0, upd_gap});
    assign res_ok     = (res_status_reg == ST_OK);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sel_next        = sel_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        fresh_next      = fresh_reg;
        job_next        = job_reg;
        res_status_next = res_status_reg;
        gap_next        = gap_reg;
        total_next      = total_reg;
        active_cnt_next = active_cnt_reg;
        last_sweep_next = last_sweep_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        job_pop         = 1'b0;
        clear_slot      = 1'b0;
        write_slot      = 1'b0;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                idx_next        = '0;
                sel_next        = '0;
                free_found_next = 1'b0;
                fresh_next      = 1'b0;
                gap_next        = '0;
                total_next      = '0;
                res_status_next = job_reg.status;
                if (sweep_due) begin
                    last_sweep_next = job_reg.now_ms;
                    state_next      = S_SWEEP;
                end else if (job_reg.status == ST_OK) begin
                    state_next = S_MATCH;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP: begin
                if (expire) begin
                    clear_slot      = 1'b1;
                    active_cnt_next = active_cnt_reg - 1'b1;
                end
                if (last_idx) begin
                    idx_next   = '0;
                    state_next = (job_reg.status == ST_OK) ? S_MATCH : S_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MATCH: begin
                if (hit) begin
                    sel_next   = idx_reg;
                    state_next = S_UPDATE;
                end else begin
                    if (!slot_active_reg[idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (last_idx) begin
                        if (free_found_reg || !slot_active_reg[idx_reg]) begin
                            sel_next   = free_found_reg ? free_idx_reg : idx_reg;
                            fresh_next = 1'b1;
                            state_next = S_UPDATE;
                        end else begin
                            res_status_next = ST_FULL;
                            state_next      = S_FINISH;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_UPDATE: begin
                write_slot = 1'b1;
                gap_next   = upd_gap;
                total_next = upd_total;
                if (fresh_reg) begin
                    active_cnt_next = active_cnt_reg + 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = res_status_reg;
                    out_data_next.slot_index   = res_ok ? 2'(sel_reg) : 2'd0;
                    out_data_next.new_peer     = res_ok && fresh_reg;
                    out_data_next.gap_now      = res_ok ? gap_reg : 16'd0;
                    out_data_next.gap_total    = res_ok ? total_reg : 32'd0;
                    out_data_next.peers_active = 3'(active_cnt_reg);
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table payload; only the active bits need a reset
    always_ff @(posedge aclk) begin
        if (write_slot) begin
            slot_ip_reg[sel_reg]        <= job_reg.source_ip;
            slot_last_seq_reg[sel_reg]  <= job_reg.seq_number;
            slot_last_seen_reg[sel_reg] <= job_reg.now_ms;
            slot_pkt_count_reg[sel_reg] <= fresh_reg ? 32'd1
                                                     : slot_pkt_count_reg[sel_reg] + 32'd1;
            slot_gap_total_reg[sel_reg] <= upd_total;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        sel_reg      <= sel_next;
        free_idx_reg <= free_idx_next;
        gap_reg      <= gap_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            free_found_reg  <= 1'b0;
            fresh_reg       <= 1'b0;
            res_status_reg  <= ST_OK;
            active_cnt_reg  <= '0;
            last_sweep_reg  <= '0;
            out_valid_reg   <= 1'b0;
            slot_active_reg <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            fresh_reg      <= fresh_next;
            res_status_reg <= res_status_next;
            active_cnt_reg <= active_cnt_next;
            last_sweep_reg <= last_sweep_next;
            out_valid_reg  <= out_valid_next;
            if (clear_slot) begin
                slot_active_reg[idx_reg] <= 1'b0;
            end else if (write_slot) begin
                slot_active_reg[sel_reg] <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `PSL_ASSERT_ALWAYS(a_count_matches, aclk, aresetn, $countones(slot_active_reg) == active_cnt_reg)
    `PSL_ASSERT_IMPL(a_load_from_finish, aclk, aresetn, $rose(out_valid_reg), $past(state_reg == S_FINISH))
    `PSL_ASSERT_IMPL(a_reject_zeroed, aclk, aresetn, out_valid_reg && (out_data_reg.status != ST_OK), (out_data_reg.slot_index == 2'd0) && !out_data_reg.new_peer && (out_data_reg.gap_total == 32'd0))
    `PSL_ASSERT_IMPL(a_claim_had_free, aclk, aresetn, (state_reg == S_UPDATE) && fresh_reg, !slot_active_reg[sel_reg])

endmodule

// ===== hdl/peer_session_table_with_loss_count_top.sv =====
// Top level of the peer session table: APB register file, stream ports, wiring.
// Depends on psl_pkg, psl_front, psl_queue and psl_back.
`timescale 1ns / 1ps

// Peer session table with sequence-loss counting. Each input item is one
// pre-parsed packet header; each produces exactly one result item, in order.
// The front end checks length, magic, version, type and payload length as the
// item is taken and drops the verdict into a two-entry job queue, so the input
// keeps flowing while the table engine is busy or a result waits on m_tready,
// until the queue fills. The table engine then, if more than sweep_interval_ms
// has passed since the last sweep, walks every slot and frees those idle longer
// than idle_timeout_ms; for a packet that passed the checks it walks the slots
// looking for the source IP (taking the lowest free slot if none matches),
// counts the 16-bit sequence gap into the slot's 32-bit loss total, and loads
// the result register. Both walks visit one slot per cycle, and the engine
// takes the next item from the queue only once the last result is loaded.
// Time comparisons use modular 32-bit differences; an age equal to a limit
// does not exceed it. Registers sit at byte address 4 * index (magic, version,
// type code, header bytes, packet bytes, timeout, sweep interval); writes to
// other addresses are ignored and read as zero. Configuration must be written
// by the user only while no item is in flight; the block does not enforce it.

module peer_session_table_with_loss_count_top #(
    parameter int SLOTS = psl_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psl_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pkt_len[15:0], magic_value[31:16], version_value[39:32], type_code[47:40],
    // seq_number[63:48], source_ip[95:64], now_ms[127:96]
    input  logic [psl_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], slot_index[4:3], new_peer[5], gap_now[21:6], gap_total[53:22],
    // peers_active[56:54], zero fill [63:57]
    output logic [psl_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import psl_pkg::*;

    logic [15:0] magic_reg;
    logic [7:0]  version_reg;
    logic [7:0]  type_reg;
    logic [15:0] hdr_bytes_reg;
    logic [15:0] pkt_bytes_reg;
    logic [31:0] timeout_reg;
    logic [31:0] sweep_reg;

    logic        cfg_wr;
    logic [2:0]  reg_idx;
    psl_cfg_t    cfg;

    logic        q_full;
    logic        q_push;
    psl_job_t    q_in_job;
    logic        q_empty;
    logic        q_pop;
    psl_job_t    q_head_job;
    psl_result_t result;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg     <= '0;
            version_reg   <= '0;
            type_reg      <= '0;
            hdr_bytes_reg <= '0;
            pkt_bytes_reg <= '0;
            timeout_reg   <= RESET_TIMEOUT_MS;
            sweep_reg     <= RESET_SWEEP_MS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MAGIC:     magic_reg     <= pwdata[15:0];
                REG_VERSION:   version_reg   <= pwdata[7:0];
                REG_TYPE:      type_reg      <= pwdata[7:0];
                REG_HDR_BYTES: hdr_bytes_reg <= pwdata[15:0];
                REG_PKT_BYTES: pkt_bytes_reg <= pwdata[15:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata;
                REG_SWEEP:     sweep_reg     <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAGIC:     prdata = {16'd0, magic_reg};
            REG_VERSION:   prdata = {24'd0, version_reg};
            REG_TYPE:      prdata = {24'd0, type_reg};
            REG_HDR_BYTES: prdata = {16'd0, hdr_bytes_reg};
            REG_PKT_BYTES: prdata = {16'd0, pkt_bytes_reg};
            REG_TIMEOUT:   prdata = timeout_reg;
            REG_SWEEP:     prdata = sweep_reg;
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.expected_magic     = magic_reg;
    assign cfg.expected_version   = version_reg;
    assign cfg.input_type_code    = type_reg;
    assign cfg.header_bytes       = hdr_bytes_reg;
    assign cfg.input_packet_bytes = pkt_bytes_reg;
    assign cfg.idle_timeout_ms    = timeout_reg;
    assign cfg.sweep_interval_ms  = sweep_reg;

    // ---------------- front end: checks ----------------
    psl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in_job)
    );

    // ---------------- job queue ----------------
    psl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head_job)
    );

    // ---------------- table engine ----------------
    psl_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (!q_empty),
        .job       (q_head_job),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {7'd0, result.peers_active, result.gap_total, result.gap_now,
                      result.new_peer, result.slot_index, result.status};

endmodule

// ===== dv/psl_session_checker.sv =====
// Result checker for the peer session table: mirrors the registers from the
// APB writes, predicts one result per accepted header and compares the stream.
// Depends on psl_pkg for status codes, register indexes and the result layout.
`timescale 1ns / 1ps

module psl_session_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psl_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    input  logic [31:0]                     prdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [psl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [psl_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              mismatch_count,
    output int                              results_owed
);
    import psl_pkg::*;

    localparam int NSLOT = SLOTS_DEF;

    psl_cfg_t    cfg;
    logic        peer_on   [NSLOT];
    logic [31:0] peer_addr [NSLOT];
    logic [15:0] peer_seq  [NSLOT];
    logic [31:0] peer_seen [NSLOT];
    logic [31:0] peer_pkts [NSLOT];
    logic [31:0] peer_loss [NSLOT];
    int          peers_on;
    logic [31:0] swept_at;

    psl_result_t owed_results [$];

    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_MAGIC:     return {16'h0, cfg.expected_magic};
            REG_VERSION:   return {24'h0, cfg.expected_version};
            REG_TYPE:      return {24'h0, cfg.input_type_code};
            REG_HDR_BYTES: return {16'h0, cfg.header_bytes};
            REG_PKT_BYTES: return {16'h0, cfg.input_packet_bytes};
            REG_TIMEOUT:   return cfg.idle_timeout_ms;
            REG_SWEEP:     return cfg.sweep_interval_ms;
            default:       return 32'h0;
        endcase
    endfunction

    // Advances the session table by one header and returns its result.
    function automatic psl_result_t predict_result(input logic [IN_TDATA_W-1:0] hdr);
        logic [15:0] len, magic, seq, nxt;
        logic [7:0]  ver, typ;
        logic [31:0] ip, now, age;
        psl_result_t res;
        int          hit;
        len   = hdr[15:0];
        magic = hdr[31:16];
        ver   = hdr[39:32];
        typ   = hdr[47:40];
        seq   = hdr[63:48];
        ip    = hdr[95:64];
        now   = hdr[127:96];
        res   = '0;
        hit   = -1;

        // idle sweep runs ahead of every header check
        age = now - swept_at;
        if (age > cfg.sweep_interval_ms) begin
            for (int i = 0; i < NSLOT; i++) begin
                age = now - peer_seen[i];
                if (peer_on[i] && age > cfg.idle_timeout_ms) begin
                    peer_on[i] = 1'b0;
                    if (peers_on > 0) peers_on--;
                end
            end
            swept_at = now;
        end

        if (len < cfg.header_bytes)             res.status = ST_SHORT;
        else if (magic != cfg.expected_magic)   res.status = ST_MAGIC;
        else if (ver != cfg.expected_version)   res.status = ST_VERSION;
        else if (typ != cfg.input_type_code)    res.status = ST_TYPE;
        else if (len < cfg.input_packet_bytes)  res.status = ST_PAYLOAD;
        else                                    res.status = ST_OK;

        if (res.status == ST_OK) begin
            for (int i = 0; i < NSLOT; i++)
                if (hit < 0 && peer_on[i] && peer_addr[i] == ip) hit = i;
            if (hit < 0) begin
                for (int i = 0; i < NSLOT; i++)
                    if (hit < 0 && !peer_on[i]) hit = i;
                if (hit >= 0) begin
                    peer_on[hit]   = 1'b1;
                    peer_addr[hit] = ip;
                    peer_seq[hit]  = 16'h0;
                    peer_seen[hit] = now;
                    peer_pkts[hit] = 32'h0;
                    peer_loss[hit] = 32'h0;
                    peers_on++;
                    res.new_peer = 1'b1;
                end
            end
            if (hit < 0) begin
                res.status = ST_FULL;
            end else begin
                nxt = peer_seq[hit] + 16'd1;
                // no gap on the first packet of a session
                if (peer_pkts[hit] != 0 && seq != nxt) begin
                    res.gap_now = seq - nxt;
                    peer_loss[hit] = peer_loss[hit] + {16'h0, res.gap_now};
                end
                peer_seq[hit]  = seq;
                peer_seen[hit] = now;
                peer_pkts[hit] = peer_pkts[hit] + 32'd1;
                res.slot_index = hit[1:0];
                res.gap_total  = peer_loss[hit];
            end
        end
        res.peers_active = peers_on[2:0];
        return res;
    endfunction

    function automatic string show_result(input psl_result_t r);
        return $sformatf("status=%0d slot=%0d new=%0b gap=%0d total=%0d peers=%0d",
                         r.status, r.slot_index, r.new_peer, r.gap_now, r.gap_total,
                         r.peers_active);
    endfunction

    task automatic note_mismatch(input string what, input string want_s, input string got_s);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s at %0t: expected %s, got %s", what, $realtime, want_s, got_s);
    endtask

    always @(posedge aclk) begin
        psl_result_t want, got;
        logic [2:0]  idx;
        if (!aresetn) begin
            cfg = '0;
            cfg.idle_timeout_ms   = RESET_TIMEOUT_MS;
            cfg.sweep_interval_ms = RESET_SWEEP_MS;
            for (int i = 0; i < NSLOT; i++) begin
                peer_on[i]   = 1'b0;
                peer_addr[i] = 32'h0;
                peer_seq[i]  = 16'h0;
                peer_seen[i] = 32'h0;
                peer_pkts[i] = 32'h0;
                peer_loss[i] = 32'h0;
            end
            peers_on = 0;
            swept_at = 32'h0;
            owed_results.delete();
        end else begin
            idx = paddr[ADDR_W-1:2];
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (idx)
                        REG_MAGIC:     cfg.expected_magic     = pwdata[15:0];
                        REG_VERSION:   cfg.expected_version   = pwdata[7:0];
                        REG_TYPE:      cfg.input_type_code    = pwdata[7:0];
                        REG_HDR_BYTES: cfg.header_bytes       = pwdata[15:0];
                        REG_PKT_BYTES: cfg.input_packet_bytes = pwdata[15:0];
                        REG_TIMEOUT:   cfg.idle_timeout_ms    = pwdata;
                        REG_SWEEP:     cfg.sweep_interval_ms  = pwdata;
                        default: begin end
                    endcase
                end else if (prdata !== reg_value(idx)) begin
                    note_mismatch($sformatf("register %0d readback", idx),
                                  $sformatf("%08h", reg_value(idx)), $sformatf("%08h", prdata));
                end
            end

            // pop before push so a result never pairs with an item taken on the same edge
            if (m_tvalid && m_tready) begin
                got.status       = m_tdata[2:0];
                got.slot_index   = m_tdata[4:3];
                got.new_peer     = m_tdata[5];
                got.gap_now      = m_tdata[21:6];
                got.gap_total    = m_tdata[53:22];
                got.peers_active = m_tdata[56:54];
                if (owed_results.size() == 0) begin
                    note_mismatch("unexpected result", "nothing", show_result(got));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status || got.slot_index !== want.slot_index ||
                        got.new_peer !== want.new_peer || got.gap_now !== want.gap_now ||
                        got.gap_total !== want.gap_total ||
                        got.peers_active !== want.peers_active ||
                        m_tdata[OUT_TDATA_W-1:57] !== '0)
                        note_mismatch("result", show_result(want),
                                      {show_result(got),
                                       $sformatf(" fill=%0h", m_tdata[OUT_TDATA_W-1:57])});
                end
            end

            if (s_tvalid && s_tready)
                owed_results.push_back(predict_result(s_tdata));
        end
        results_owed = owed_results.size();
    end

endmodule

// ===== dv/peer_session_table_with_loss_count_top_test.sv =====
// Testbench top for the peer session table: clock, reset, APB and stream stimulus.
// Depends on psl_pkg, the block top and psl_session_checker, which does all checking.
`timescale 1ns / 1ps

module peer_session_table_with_loss_count_top_test;
    import psl_pkg::*;

    localparam int CLK_HALF        = 6;       // 12 ns period
    localparam int RESET_CYCLES    = 6;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int POOL            = 6;       // more peers than slots, so the table fills
    localparam int SETTLE_CYCLES   = 24;      // settle time after the last result, before registers are touched
    localparam int CYCLE_LIMIT     = 600000;

    // index past the register map; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // fixed peers for the directed part: all-zero and all-one addresses included
    localparam logic [31:0] IP_A = 32'h0000_0000;
    localparam logic [31:0] IP_B = 32'hFFFF_FFFF;
    localparam logic [31:0] IP_C = 32'hC0A8_0101;
    localparam logic [31:0] IP_D = 32'h0A00_0002;
    localparam logic [31:0] IP_E = 32'h7F00_0001;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_owed;
    int cycle_count  = 0;
    int src_idle_pct = 26;
    int sink_idle_pct = 70;

    // register values as last written, used to shape the headers
    logic [15:0] cur_magic;
    logic [7:0]  cur_ver;
    logic [7:0]  cur_type;
    logic [15:0] cur_hdr;
    logic [15:0] cur_pkt;
    logic [31:0] cur_timeout;
    logic [31:0] cur_sweep;

    logic [31:0] now_clk;
    logic [31:0] peer_ip  [POOL];
    logic [15:0] peer_seq [POOL];

    peer_session_table_with_loss_count_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    psl_session_checker session_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Result side back-pressure: one fresh draw per edge, never two writes in a step.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog, far beyond the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("peer_session_table_with_loss_count_top_test failed");
            $finish;
        end
    end

    // Header item layout, lowest bits first:
    // pkt_len, magic_value, version_value, type_code, seq_number, source_ip, now_ms
    function automatic logic [IN_TDATA_W-1:0] pack_header(
        input logic [15:0] len, input logic [15:0] magic, input logic [7:0] ver,
        input logic [7:0] typ, input logic [15:0] seq, input logic [31:0] ip,
        input logic [31:0] now);
        return {now, ip, seq, typ, ver, magic, len};
    endfunction

    // One APB transfer: setup then access. The trailing idle cycle keeps
    // back-to-back calls from driving psel twice in one step.
    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (wr) begin
            case (idx)
                REG_MAGIC:     cur_magic   = value[15:0];
                REG_VERSION:   cur_ver     = value[7:0];
                REG_TYPE:      cur_type    = value[7:0];
                REG_HDR_BYTES: cur_hdr     = value[15:0];
                REG_PKT_BYTES: cur_pkt     = value[15:0];
                REG_TIMEOUT:   cur_timeout = value;
                REG_SWEEP:     cur_sweep   = value;
                default: begin end
            endcase
        end
    endtask

    // Offers one header item and returns on the edge that takes it. s_tvalid is
    // left high so the next call either keeps it up with new data or drops it.
    task automatic send_word(input logic [IN_TDATA_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the input back until every owed result has come out, then lets the
    // engine settle; registers are only touched after this.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the whole register map for one phase, plus a readback pass.
    task automatic load_phase_config(input int p);
        logic [31:0] mg, vr, ty, hb, pb, tmo, swp;
        mg = $urandom;
        vr = $urandom;
        ty = $urandom;
        case (p)
            0: begin hb = 20;    pb = 64;   tmo = 5000;         swp = 1000;         end
            1: begin mg = 0; vr = 0; ty = 0;
                     hb = 0;     pb = 0;    tmo = 0;            swp = 0;            end
            2: begin mg = 32'hFFFF; vr = 32'hFF; ty = 32'hFF;
                     hb = 10;    pb = 8;    tmo = 32'hFFFF_FFFF; swp = 32'hFFFF_FFFF; end
            3: begin hb = 0;     pb = 1500; tmo = 300;          swp = 100;          end
            4: begin hb = 14;    pb = 14;   tmo = 2000;         swp = 0;            end
            5: begin hb = 64;    pb = 128;  tmo = 0;            swp = 500;          end
            6: begin hb = 1;     pb = 2;    tmo = 32'hFFFF_FFFF; swp = 10;          end
            7: begin hb = 30;    pb = 60;   tmo = 800;          swp = 800;          end
            8: begin mg = 32'hFFFF; vr = 0; ty = 32'hFF;
                     hb = 32'hFFFF; pb = 0; tmo = 100000;       swp = 20000;        end
            default: begin hb = 20; pb = 64; tmo = 5000;        swp = 1000;         end
        endcase
        apb_access(1'b1, REG_MAGIC,     mg);
        apb_access(1'b1, REG_VERSION,   vr);
        apb_access(1'b1, REG_TYPE,      ty);
        apb_access(1'b1, REG_HDR_BYTES, hb);
        apb_access(1'b1, REG_PKT_BYTES, pb);
        apb_access(1'b1, REG_TIMEOUT,   tmo);
        apb_access(1'b1, REG_SWEEP,     swp);
        for (int i = REG_MAGIC; i <= REG_SWEEP; i++)
            apb_access(1'b0, i[2:0], 32'h0);
    endtask

    // Random header: time steps aimed at the sweep and timeout edges, peers from
    // a small pool with mostly in-order sequence numbers, and a share of
    // rejected and fully random items.
    function automatic logic [IN_TDATA_W-1:0] next_header();
        int          pick;
        int          k;
        logic [31:0] step, cap, ip;
        logic [15:0] len, magic, seq, floor_len;
        logic [7:0]  ver, typ;

        cap  = (cur_sweep < 64) ? 32'd3 : (((cur_sweep >> 4) > 500) ? 32'd500 : cur_sweep >> 4);
        pick = $urandom_range(99);
        if (pick < 55)      step = $urandom_range(0, cap);
        else if (pick < 75) step = cur_sweep + $urandom_range(0, 2) - 1;
        else if (pick < 90) step = cur_timeout + $urandom_range(0, 2) - 1;
        else if (pick < 95) step = 0;
        else                step = $urandom;
        now_clk = now_clk + step;

        k    = $urandom_range(0, POOL - 1);
        ip   = peer_ip[k];
        pick = $urandom_range(99);
        if (pick < 70)      seq = peer_seq[k];
        else if (pick < 85) seq = 16'(peer_seq[k] + $urandom_range(1, 5));
        else if (pick < 92) seq = 16'($urandom);
        else                seq = 16'(peer_seq[k] - $urandom_range(0, 3));
        peer_seq[k] = seq + 16'd1;

        floor_len = (cur_hdr > cur_pkt) ? cur_hdr : cur_pkt;
        if ($urandom_range(3) == 0) len = floor_len;
        else                        len = 16'(floor_len +
                                              $urandom_range(0, 16'hFFFF - floor_len));
        magic = cur_magic;
        ver   = cur_ver;
        typ   = cur_type;

        pick = $urandom_range(99);
        if (pick < 72) begin
            // well formed
        end else if (pick < 76) begin
            if (cur_hdr != 0) len = 16'($urandom_range(0, cur_hdr - 1));
        end else if (pick < 80) begin
            magic = cur_magic ^ 16'($urandom_range(1, 16'hFFFF));
        end else if (pick < 84) begin
            ver = cur_ver ^ 8'($urandom_range(1, 8'hFF));
        end else if (pick < 88) begin
            typ = cur_type ^ 8'($urandom_range(1, 8'hFF));
        end else if (pick < 92) begin
            if (cur_pkt > cur_hdr) len = 16'($urandom_range(cur_hdr, cur_pkt - 1));
        end else begin
            len   = 16'($urandom);
            magic = 16'($urandom);
            ver   = 8'($urandom);
            typ   = 8'($urandom);
            seq   = 16'($urandom);
            if ($urandom_range(1)) ip = $urandom;
        end
        return pack_header(len, magic, ver, typ, seq, ip, now_clk);
    endfunction

    // Replaces one randomly chosen pool peer with a fresh address and sequence.
    task automatic k_refresh();
        int k;
        k = $urandom_range(0, POOL - 1);
        peer_ip[k]  = $urandom;
        peer_seq[k] = 16'($urandom);
    endtask

    initial begin
        cur_magic   = 16'h0;
        cur_ver     = 8'h0;
        cur_type    = 8'h0;
        cur_hdr     = 16'h0;
        cur_pkt     = 16'h0;
        cur_timeout = RESET_TIMEOUT_MS;
        cur_sweep   = RESET_SWEEP_MS;
        for (int i = 0; i < POOL; i++) begin
            peer_ip[i]  = $urandom;
            peer_seq[i] = 16'($urandom);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, reset register values (all checks pass on zeros) ----
        send_word(pack_header(16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000, IP_A, 32'd0));
        send_word(pack_header(16'hFFFF, 16'h0000, 8'h00, 8'h00, 16'h0001, IP_A, 32'd10));
        // forward gap, then a step backwards that wraps to a large gap
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0005, IP_A, 32'd20));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0000, IP_A, 32'd30));
        // sequence wrap from 65535 to 0 is in order
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'hFFFF, IP_B, 32'd40));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0000, IP_B, 32'd50));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'd100,  IP_C, 32'd60));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'd7,    IP_D, 32'd70));
        // fifth peer: table full
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0000, IP_E, 32'd80));
        send_word(pack_header(16'h0010, 16'hFFFF, 8'h00, 8'h00, 16'h0000, IP_E, 32'd90));
        send_word(pack_header(16'h0010, 16'h0000, 8'hFF, 8'h00, 16'h0000, IP_E, 32'd95));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'hFF, 16'h0000, IP_E, 32'd99));
        // elapsed time equal to the sweep interval: no sweep yet
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0001, IP_A, 32'd1000));
        // sweep runs but nobody is idle long enough, still full
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0000, IP_E, 32'd1001));
        // A's age equals the timeout and it stays; the others go, E takes slot 1
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'd9,    IP_E, 32'd6000));
        // clock near the wrap point, then across it
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0002, IP_A, 32'hFFFF_FFF0));
        send_word(pack_header(16'h0010, 16'h0000, 8'h00, 8'h00, 16'h0003, IP_A, 32'h0000_0010));
        drain_results();

        // every check at its upper extreme; the unmapped index must be dropped
        apb_access(1'b1, REG_MAGIC,     32'h0000_FFFF);
        apb_access(1'b1, REG_VERSION,   32'h0000_00FF);
        apb_access(1'b1, REG_TYPE,      32'h0000_00FF);
        apb_access(1'b1, REG_HDR_BYTES, 32'h0000_FFFF);
        apb_access(1'b1, REG_PKT_BYTES, 32'h0000_FFFF);
        apb_access(1'b1, REG_UNUSED,    $urandom);
        for (int i = REG_MAGIC; i <= REG_SWEEP; i++)
            apb_access(1'b0, i[2:0], 32'h0);
        send_word(pack_header(16'hFFFE, 16'hFFFF, 8'hFF, 8'hFF, 16'h0004, IP_A, 32'h0000_0011));
        send_word(pack_header(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'h0004, IP_A, 32'h0000_0011));
        drain_results();

        // check order: short wins over bad magic, magic over version
        apb_access(1'b1, REG_HDR_BYTES, 32'd20);
        apb_access(1'b1, REG_PKT_BYTES, 32'd64);
        send_word(pack_header(16'd19, 16'h1234, 8'hFF, 8'hFF, 16'h0005, IP_A, 32'h0000_0011));
        send_word(pack_header(16'd20, 16'h1234, 8'h00, 8'hFF, 16'h0005, IP_A, 32'h0000_0011));
        send_word(pack_header(16'd40, 16'hFFFF, 8'hFF, 8'hFF, 16'h0005, IP_A, 32'h0000_0011));
        send_word(pack_header(16'd64, 16'hFFFF, 8'hFF, 8'hFF, 16'h0005, IP_A, 32'h0000_0011));
        drain_results();

        // zero timeout and interval: any clock change sweeps, any nonzero age frees
        apb_access(1'b1, REG_TIMEOUT, 32'd0);
        apb_access(1'b1, REG_SWEEP,   32'd0);
        send_word(pack_header(16'd64, 16'hFFFF, 8'hFF, 8'hFF, 16'h0000, IP_B, 32'h0000_0012));
        send_word(pack_header(16'd64, 16'hFFFF, 8'hFF, 8'hFF, 16'h0001, IP_B, 32'h0000_0012));
        now_clk = 32'h0000_0012;

        // ---- random phases: sender/receiver idling, then reversed, then none ----
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p < 4) begin
                src_idle_pct  = 26;
                sink_idle_pct = 70;
            end else if (p < 7) begin
                src_idle_pct  = 70;
                sink_idle_pct = 26;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            load_phase_config(p);
            // turn over part of the peer pool so new sessions keep appearing
            repeat (2) k_refresh();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mid-phase the sender stops until the pipeline is empty
                if (n == ITEMS_PER_PHASE / 2) drain_results();
                send_word(next_header());
            end
        end
        drain_results();

        if (mismatch_count == 0 && results_owed == 0)
            $display("peer_session_table_with_loss_count_top_test passed");
        else
            $display("peer_session_table_with_loss_count_top_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/psl_pkg.sv
hdl/psl_front.sv
hdl/psl_queue.sv
hdl/psl_back.sv
hdl/peer_session_table_with_loss_count_top.sv
dv/psl_session_checker.sv
dv/peer_session_table_with_loss_count_top_test.sv
